### rtl/slmp_pkg.sv
package slmp_pkg;

  // Output codes: 0.001 rounded up in Q16.16, and the saturated top of the range.
  localparam logic [31:0] FLOOR_CODE = 32'd66;
  localparam logic [31:0] MAX_CODE   = 32'hFFFF_FFFF;

  // Averaging count after reset.
  localparam logic [4:0] AVG_RESET = 5'd8;

  // Width of sqrt(n/2) in Q16.16, enough for every count up to 64.
  localparam int K_W = 19;

  // Control word that travels with each item down the pipeline.
  typedef struct packed {
    logic [10:0] bin;
    logic        last;
    logic        fixed_floor;
  } tag_t;

  // floor(sqrt(n * 2^31)), that is sqrt(n/2) in Q16.16. Only ever called with
  // constant arguments, so it folds to a table at elaboration.
  function automatic logic [K_W-1:0] sqrt_half_count(input int unsigned n);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bv;
    x   = 64'(n) << 31;
    res = '0;
    bv  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + bv) begin
        x   = x - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return K_W'(res);
  endfunction

endpackage

### rtl/spectral_lmp_detector.sv
// Spectral LMP detector. Each accepted word carries the power of one spectral bin; it is
// written into the current row of a history of the last spectra (one memory bank per row,
// all banks read together) and one result word comes back per input word, in order. The
// pipeline takes one word every cycle; a stall on the result side freezes the whole
// pipeline and holds bin_stall high until the result is taken. After reset the history
// is cleared by a pass over all FFT_SIZE/2+1 addresses, one address of every bank per
// cycle, during which bin_stall is high; average_count may be written at any time the
// block is idle, including during that pass.
module spectral_lmp_detector #(
  parameter int MAX_SPECTRA = 16,
  parameter int FFT_SIZE    = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        average_count_we,
  input  logic [4:0]  average_count,
  input  logic        bin_valid,
  output logic        bin_stall,
  input  logic [31:0] bin_power,
  input  logic [10:0] bin_index,
  input  logic        last_bin,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] detector_value,
  output logic [10:0] result_bin,
  output logic        result_last
);
  import slmp_pkg::*;

  localparam int BIN_COUNT = FFT_SIZE / 2 + 1;
  localparam int AW        = $clog2(BIN_COUNT);
  localparam int RW        = $clog2(MAX_SPECTRA);
  localparam int CW        = $clog2(MAX_SPECTRA + 1);
  localparam int SUM_W     = 32 + RW;
  localparam int SQ_W      = 48 + RW;
  localparam int DIV_STEPS = 8;
  localparam int MEAN_ST   = (SUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int MEAN_W    = MEAN_ST * DIV_STEPS;
  localparam int VAR_ST    = (SQ_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int VAR_W     = VAR_ST * DIV_STEPS;
  localparam int ROOT_ST   = 16;
  localparam int QUO_ST    = 16;
  localparam int GA        = (MAX_SPECTRA + 3) / 4;
  localparam int GB        = (GA + 3) / 4;
  localparam int PW        = K_W + 32;

  // Stage numbers: the register stage at which each part of the work ends.
  localparam int ST_RD  = 1;
  localparam int ST_X   = 2;
  localparam int ST_SUM = ST_X + 3;
  localparam int ST_M   = ST_SUM + MEAN_ST;
  localparam int ST_E1  = ST_M + 1;
  localparam int ST_E2  = ST_M + 2;
  localparam int ST_SQ  = ST_E2 + 3;
  localparam int ST_VAR = ST_SQ + VAR_ST;
  localparam int ST_V   = ST_VAR + 1;
  localparam int ST_R   = ST_V + ROOT_ST;
  localparam int ST_P1  = ST_R + 1;
  localparam int ST_P2  = ST_P1 + 1;
  localparam int ST_Q   = ST_P2 + QUO_ST;
  localparam int LAT    = ST_Q + 1;

  // Control state.
  logic          clearing;
  logic [AW-1:0] clr_addr;
  logic [4:0]    count_cfg;
  logic [RW-1:0] current_row;
  logic [RW-1:0] row_eff;
  logic [RW-1:0] row_next;
  logic [CW-1:0] n_eff;
  logic [CW-1:0] row_inc;
  logic          adv;
  logic          accept;
  logic          in_range;
  logic [AW-1:0] wr_addr;
  logic          v_p [1:LAT];
  tag_t          tag_p [1:LAT];

  // The pipeline moves whenever the output register is empty or being taken.
  assign adv       = !result_valid || !result_stall;
  assign bin_stall = clearing || !adv;
  assign accept    = bin_valid && !bin_stall;
  assign in_range  = int'(bin_index) < BIN_COUNT;
  assign wr_addr   = AW'(bin_index);

  // Effective count, clamped into the supported range.
  always_comb begin
    if (count_cfg < 5'd2) begin
      n_eff = CW'(2);
    end else if (int'(count_cfg) > MAX_SPECTRA) begin
      n_eff = CW'(MAX_SPECTRA);
    end else begin
      n_eff = CW'(count_cfg);
    end
  end

  // A row left beyond a shrunken count restarts at row zero.
  always_comb begin
    row_eff = (CW'(current_row) >= n_eff) ? '0 : current_row;
    row_inc = CW'(row_eff) + CW'(1);
    row_next = (row_inc >= n_eff) ? '0 : RW'(row_inc);
  end

  // Configuration, ring row and clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_cfg   <= AVG_RESET;
      current_row <= '0;
      clearing    <= 1'b1;
      clr_addr    <= '0;
    end else begin
      if (average_count_we) begin
        count_cfg <= average_count;
      end
      if (accept) begin
        current_row <= last_bin ? row_next : row_eff;
      end
      if (clearing) begin
        if (clr_addr == AW'(BIN_COUNT - 1)) begin
          clearing <= 1'b0;
        end else begin
          clr_addr <= clr_addr + AW'(1);
        end
      end
    end
  end

  // Valid bits and control words travel down the pipeline together.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= LAT; s++) begin
        v_p[s] <= 1'b0;
      end
    end else if (adv) begin
      v_p[1] <= accept;
      for (int s = 2; s <= LAT; s++) begin
        v_p[s] <= v_p[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_p[1] <= '{bin: bin_index, last: last_bin,
                    fixed_floor: !in_range || (bin_index == '0)};
      for (int s = 2; s <= LAT; s++) begin
        tag_p[s] <= tag_p[s-1];
      end
    end
  end

  // History banks, one per row. The incoming word is written and all rows are read at the
  // same address; the own row is replaced by the incoming power at stage ST_X.
  logic [31:0]   rd [MAX_SPECTRA];
  logic [31:0]   pow1;
  logic [RW-1:0] row1;

  for (genvar b = 0; b < MAX_SPECTRA; b++) begin : g_bank
    logic [31:0] bank [BIN_COUNT];
    always_ff @(posedge clk) begin
      if (clearing) begin
        bank[clr_addr] <= '0;
      end else if (accept && in_range && (row_eff == RW'(b))) begin
        bank[wr_addr] <= bin_power;
      end
      if (adv) begin
        rd[b] <= bank[wr_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pow1 <= bin_power;
      row1 <= row_eff;
    end
  end

  // Row values, rows beyond the count read as zero; carried until the mean is known.
  logic [31:0] xp [ST_X:ST_M][MAX_SPECTRA];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < MAX_SPECTRA; j++) begin
        if (CW'(j) < n_eff) begin
          xp[ST_X][j] <= (row1 == RW'(j)) ? pow1 : rd[j];
        end else begin
          xp[ST_X][j] <= '0;
        end
      end
    end
  end

  for (genvar s = ST_X + 1; s <= ST_M; s++) begin : g_xcarry
    always_ff @(posedge clk) begin
      if (adv) begin
        xp[s] <= xp[s-1];
      end
    end
  end

  // Sum over rows: a registered tree of four-input adders.
  logic [33:0] sa [GA];
  logic [33:0] sa_next [GA];
  logic [35:0] sb [GB];
  logic [35:0] sb_next [GB];
  logic [SUM_W-1:0] sum_next;

  always_comb begin
    logic [39:0] acc;
    for (int g = 0; g < GA; g++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        if (4 * g + k < MAX_SPECTRA) begin
          acc = acc + 40'(xp[ST_X][4*g+k]);
        end
      end
      sa_next[g] = 34'(acc);
    end
    for (int g = 0; g < GB; g++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        if (4 * g + k < GA) begin
          acc = acc + 40'(sa[4*g+k]);
        end
      end
      sb_next[g] = 36'(acc);
    end
    acc = '0;
    for (int g = 0; g < GB; g++) begin
      acc = acc + 40'(sb[g]);
    end
    sum_next = SUM_W'(acc);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa <= sa_next;
      sb <= sb_next;
    end
  end

  // Mean: restoring division by the count, eight quotient bits per stage.
  logic [CW-1:0]     mrem [ST_SUM:ST_M];
  logic [MEAN_W-1:0] mq   [ST_SUM:ST_M];

  always_ff @(posedge clk) begin
    if (adv) begin
      mrem[ST_SUM] <= '0;
      mq[ST_SUM]   <= MEAN_W'(sum_next);
    end
  end

  for (genvar s = ST_SUM + 1; s <= ST_M; s++) begin : g_mean
    logic [CW-1:0]     rem_next;
    logic [MEAN_W-1:0] q_next;
    always_comb begin
      logic [CW:0]       r;
      logic [MEAN_W-1:0] q;
      r = {1'b0, mrem[s-1]};
      q = mq[s-1];
      for (int k = 0; k < DIV_STEPS; k++) begin
        r = {r[CW-1:0], q[MEAN_W-1]};
        q = {q[MEAN_W-2:0], 1'b0};
        if (r >= {1'b0, n_eff}) begin
          r    = r - {1'b0, n_eff};
          q[0] = 1'b1;
        end
      end
      rem_next = r[CW-1:0];
      q_next   = q;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        mrem[s] <= rem_next;
        mq[s]   <= q_next;
      end
    end
  end

  // Deviations from the mean, their squares, and the square of the mean.
  logic [31:0] mean_d;
  logic [31:0] mp  [ST_E1:ST_P1];
  logic [47:0] m2p [ST_E1:ST_VAR];
  logic [31:0] dp  [MAX_SPECTRA];
  logic [47:0] dsq [MAX_SPECTRA];
  logic [63:0] msq;

  assign mean_d = mq[ST_M][31:0];
  assign msq    = 64'(mean_d) * 64'(mean_d);

  always_ff @(posedge clk) begin
    if (adv) begin
      mp[ST_E1]  <= mean_d;
      m2p[ST_E1] <= msq[63:16];
      for (int j = 0; j < MAX_SPECTRA; j++) begin
        dp[j] <= (xp[ST_M][j] >= mean_d) ? (xp[ST_M][j] - mean_d) : (mean_d - xp[ST_M][j]);
      end
    end
  end

  for (genvar s = ST_E1 + 1; s <= ST_P1; s++) begin : g_mcarry
    always_ff @(posedge clk) begin
      if (adv) begin
        mp[s] <= mp[s-1];
      end
    end
  end

  for (genvar s = ST_E1 + 1; s <= ST_VAR; s++) begin : g_m2carry
    always_ff @(posedge clk) begin
      if (adv) begin
        m2p[s] <= m2p[s-1];
      end
    end
  end

  for (genvar j = 0; j < MAX_SPECTRA; j++) begin : g_lane
    logic [63:0] dd;
    assign dd = 64'(dp[j]) * 64'(dp[j]);
    always_ff @(posedge clk) begin
      if (adv) begin
        dsq[j] <= (CW'(j) < n_eff) ? dd[63:16] : '0;
      end
    end
  end

  // Sum of squared deviations: the same tree shape as the plain sum.
  logic [49:0] qa [GA];
  logic [49:0] qa_next [GA];
  logic [51:0] qb [GB];
  logic [51:0] qb_next [GB];
  logic [SQ_W-1:0] sq_next;

  always_comb begin
    logic [55:0] acc;
    for (int g = 0; g < GA; g++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        if (4 * g + k < MAX_SPECTRA) begin
          acc = acc + 56'(dsq[4*g+k]);
        end
      end
      qa_next[g] = 50'(acc);
    end
    for (int g = 0; g < GB; g++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        if (4 * g + k < GA) begin
          acc = acc + 56'(qa[4*g+k]);
        end
      end
      qb_next[g] = 52'(acc);
    end
    acc = '0;
    for (int g = 0; g < GB; g++) begin
      acc = acc + 56'(qb[g]);
    end
    sq_next = SQ_W'(acc);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qa <= qa_next;
      qb <= qb_next;
    end
  end

  // Sample variance: restoring division by count minus one.
  logic [CW-1:0]    n_less;
  logic [CW-1:0]    vrem [ST_SQ:ST_VAR];
  logic [VAR_W-1:0] vq   [ST_SQ:ST_VAR];

  assign n_less = n_eff - CW'(1);

  always_ff @(posedge clk) begin
    if (adv) begin
      vrem[ST_SQ] <= '0;
      vq[ST_SQ]   <= VAR_W'(sq_next);
    end
  end

  for (genvar s = ST_SQ + 1; s <= ST_VAR; s++) begin : g_var
    logic [CW-1:0]    rem_next;
    logic [VAR_W-1:0] q_next;
    always_comb begin
      logic [CW:0]      r;
      logic [VAR_W-1:0] q;
      r = {1'b0, vrem[s-1]};
      q = vq[s-1];
      for (int k = 0; k < DIV_STEPS; k++) begin
        r = {r[CW-1:0], q[VAR_W-1]};
        q = {q[VAR_W-2:0], 1'b0};
        if (r >= {1'b0, n_less}) begin
          r    = r - {1'b0, n_less};
          q[0] = 1'b1;
        end
      end
      rem_next = r[CW-1:0];
      q_next   = q;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        vrem[s] <= rem_next;
        vq[s]   <= q_next;
      end
    end
  end

  // v = max(m^2 - var, 0), then its square root two result bits per stage.
  logic [VAR_W-1:0] m2_wide;
  logic [47:0]      v_next;
  logic [63:0]      sx    [ST_V:ST_R];
  logic [33:0]      srem  [ST_V:ST_R];
  logic [31:0]      sroot [ST_V:ST_R];

  assign m2_wide = VAR_W'(m2p[ST_VAR]);
  assign v_next  = (vq[ST_VAR] >= m2_wide) ? '0 : 48'(m2_wide - vq[ST_VAR]);

  always_ff @(posedge clk) begin
    if (adv) begin
      sx[ST_V]    <= {v_next, 16'b0};
      srem[ST_V]  <= '0;
      sroot[ST_V] <= '0;
    end
  end

  for (genvar s = ST_V + 1; s <= ST_R; s++) begin : g_root
    logic [63:0] x_next;
    logic [33:0] rem_next;
    logic [31:0] root_next;
    always_comb begin
      logic [63:0] x;
      logic [35:0] t;
      logic [31:0] root;
      x    = sx[s-1];
      t    = {2'b0, srem[s-1]};
      root = sroot[s-1];
      for (int k = 0; k < 2; k++) begin
        t = {t[33:0], x[63:62]};
        x = {x[61:0], 2'b0};
        if (t >= {2'b0, root, 2'b01}) begin
          t    = t - {2'b0, root, 2'b01};
          root = {root[30:0], 1'b1};
        end else begin
          root = {root[30:0], 1'b0};
        end
      end
      x_next    = x;
      rem_next  = t[33:0];
      root_next = root;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sx[s]    <= x_next;
        srem[s]  <= rem_next;
        sroot[s] <= root_next;
      end
    end
  end

  // sqrt(n/2) * r and the denominator m - r.
  logic [K_W-1:0] k_tab [MAX_SPECTRA+1];
  logic           p1_ge;
  logic [31:0]    p1_den;
  logic [PW-1:0]  p1_prod;

  for (genvar i = 0; i <= MAX_SPECTRA; i++) begin : g_ktab
    assign k_tab[i] = sqrt_half_count(i);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_ge   <= sroot[ST_R] >= mp[ST_R];
      p1_den  <= mp[ST_R] - sroot[ST_R];
      p1_prod <= PW'(k_tab[n_eff]) * PW'(sroot[ST_R]);
    end
  end

  // Final quotient: saturates when r >= m or the upper half reaches the denominator,
  // otherwise one restoring division over the lower 32 bits, two bits per stage.
  logic [31:0] qrem [ST_P2:ST_Q];
  logic [31:0] qq   [ST_P2:ST_Q];
  logic [31:0] qden [ST_P2:ST_Q];
  logic        qsat [ST_P2:ST_Q];

  always_ff @(posedge clk) begin
    if (adv) begin
      qsat[ST_P2] <= p1_ge || (32'(p1_prod[PW-1:32]) >= p1_den);
      qrem[ST_P2] <= 32'(p1_prod[PW-1:32]);
      qq[ST_P2]   <= p1_prod[31:0];
      qden[ST_P2] <= p1_den;
    end
  end

  for (genvar s = ST_P2 + 1; s <= ST_Q; s++) begin : g_quo
    logic [31:0] rem_next;
    logic [31:0] q_next;
    always_comb begin
      logic [32:0] t;
      logic [31:0] q;
      t = {1'b0, qrem[s-1]};
      q = qq[s-1];
      for (int k = 0; k < 2; k++) begin
        t = {t[31:0], q[31]};
        q = {q[30:0], 1'b0};
        if (t >= {1'b0, qden[s-1]}) begin
          t    = t - {1'b0, qden[s-1]};
          q[0] = 1'b1;
        end
      end
      rem_next = t[31:0];
      q_next   = q;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        qrem[s] <= rem_next;
        qq[s]   <= q_next;
        qden[s] <= qden[s-1];
        qsat[s] <= qsat[s-1];
      end
    end
  end

  // Output register: floor, saturation and the forced floor for DC and stray bins.
  logic [31:0] out_value;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (tag_p[ST_Q].fixed_floor) begin
        out_value <= FLOOR_CODE;
      end else if (qsat[ST_Q]) begin
        out_value <= MAX_CODE;
      end else if (qq[ST_Q] < FLOOR_CODE) begin
        out_value <= FLOOR_CODE;
      end else begin
        out_value <= qq[ST_Q];
      end
    end
  end

  assign result_valid   = v_p[LAT];
  assign detector_value = out_value;
  assign result_bin     = tag_p[LAT].bin;
  assign result_last    = tag_p[LAT].last;

  // The clearing pass ends only after the last address has been written.
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_addr) == AW'(BIN_COUNT - 1))
    else $error("clearing pass ended early");

  // No result can appear while the history is still being cleared.
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !result_valid)
    else $error("result during clearing pass");

  // The ring row stays inside the count after it advances.
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    accept && last_bin && !average_count_we |=> CW'(current_row) < $past(n_eff))
    else $error("ring row beyond count");

  // The root never exceeds the mean, so r >= m only when they are equal.
  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    v_p[ST_P1] && p1_ge |-> p1_den == '0)
    else $error("root above mean");

  // Every delivered value respects the floor.
  a_floor: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> detector_value >= FLOOR_CODE)
    else $error("value below floor");

endmodule

### sim/tb_spectral_lmp_detector.sv
module tb_spectral_lmp_detector;
  timeunit 1ns;
  timeprecision 1ps;
  import slmp_pkg::*;

  localparam int ROWS     = 16;
  localparam int BINS     = 1025;
  localparam int WATCHDOG = 20000;
  localparam int SETTLE   = 200;

  typedef struct packed {
    logic [31:0] power;
    logic [10:0] bin;
    logic        last;
  } bin_word_t;

  typedef struct packed {
    logic [31:0] value;
    logic [10:0] bin;
    logic        last;
  } lmp_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        average_count_we = 1'b0;
  logic [4:0]  average_count = '0;
  logic        bin_valid = 1'b0;
  logic        bin_stall;
  logic [31:0] bin_power = '0;
  logic [10:0] bin_index = '0;
  logic        last_bin = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [31:0] detector_value;
  logic [10:0] result_bin;
  logic        result_last;

  spectral_lmp_detector u_dut (
    .clk(clk), .rst(rst),
    .average_count_we(average_count_we), .average_count(average_count),
    .bin_valid(bin_valid), .bin_stall(bin_stall),
    .bin_power(bin_power), .bin_index(bin_index), .last_bin(last_bin),
    .result_valid(result_valid), .result_stall(result_stall),
    .detector_value(detector_value), .result_bin(result_bin), .result_last(result_last)
  );

  always #5 clk = ~clk;

  // Predictor state: history of spectra, ring row and averaging register.
  logic [31:0] power_history [ROWS][BINS];
  int unsigned ring_row;
  logic [4:0]  avg_reg;

  bin_word_t   pending_words[$];
  lmp_word_t   expected_lmp[$];
  int          error_count;
  int          idle_pct;
  bit          hold_sender;
  bit          in_taken;

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bv;
    res = '0;
    bv  = 64'd1 << 62;
    while (bv > x) bv = bv >> 2;
    while (bv != 0) begin
      if (x >= res + bv) begin
        x   = x - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  // Work out the statistic for one accepted word and update the history.
  function automatic lmp_word_t predict_lmp(input bin_word_t w);
    lmp_word_t   o;
    int unsigned n;
    logic [63:0] sum, sq, m, var_q, m2, v, r, k, q, x, d;
    n = (avg_reg < 2) ? 2 : (avg_reg > ROWS) ? ROWS : avg_reg;
    o.value = FLOOR_CODE;
    o.bin   = w.bin;
    o.last  = w.last;
    if (ring_row >= n) ring_row = 0;
    if (w.bin < BINS) begin
      power_history[ring_row][w.bin] = w.power;
      if (w.bin != 0) begin
        sum = 0;
        sq  = 0;
        for (int j = 0; j < n; j++) sum += power_history[j][w.bin];
        m = sum / n;
        for (int j = 0; j < n; j++) begin
          x = power_history[j][w.bin];
          d = (x >= m) ? x - m : m - x;
          sq += (d * d) >> 16;
        end
        var_q = sq / (n - 1);
        m2    = (m * m) >> 16;
        v     = (var_q >= m2) ? 0 : m2 - var_q;
        r     = int_sqrt(v << 16);
        if (r >= m) begin
          o.value = MAX_CODE;
        end else begin
          k = int_sqrt(64'(n) << 31);
          q = (k * r) / (m - r);
          o.value = (q > MAX_CODE) ? MAX_CODE : (q < FLOOR_CODE) ? FLOOR_CODE : q[31:0];
        end
      end
    end
    if (w.last) begin
      ring_row++;
      if (ring_row >= n) ring_row = 0;
    end
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Input acceptance is judged at the rising edge, where the block samples it.
  always @(posedge clk) begin
    in_taken = !rst && bin_valid && !bin_stall;
    if (in_taken) begin
      expected_lmp.push_back(predict_lmp('{bin_power, bin_index, last_bin}));
    end
  end

  // Driver: presents the next word at the falling edge, holds it while stalled.
  always @(negedge clk) begin
    if (!rst) begin
      if (!bin_valid || in_taken) begin
        if (pending_words.size() > 0 && !hold_sender && $urandom_range(99) >= idle_pct) begin
          {bin_power, bin_index, last_bin} <= pending_words.pop_front();
          bin_valid <= 1'b1;
        end else begin
          bin_valid <= 1'b0;
        end
      end
      result_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // Monitor: checks each accepted result word against the oldest expectation.
  always @(posedge clk) begin
    lmp_word_t e;
    if (!rst && result_valid && !result_stall) begin
      if (expected_lmp.size() == 0) begin
        report_mismatch("unexpected word, bin", 32'(result_bin), '0);
      end else begin
        e = expected_lmp.pop_front();
        if (detector_value !== e.value) report_mismatch("detector_value", detector_value, e.value);
        if (result_bin !== e.bin) report_mismatch("result_bin", 32'(result_bin), 32'(e.bin));
        if (result_last !== e.last) report_mismatch("result_last", 32'(result_last), 32'(e.last));
      end
    end
  end

  // Watchdog: counts cycles with no word moving on either side.
  int quiet_cycles;
  always @(posedge clk) begin
    if (rst || (bin_valid && !bin_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [10:0] pick_bin(input int top);
    return 11'($urandom_range(top));
  endfunction

  // Queue one spectrum of bins 0..top, with the given power style.
  task automatic queue_spectrum(input int top, input int style);
    logic [31:0] p;
    for (int b = 0; b <= top; b++) begin
      case (style)
        0: p = $urandom();
        1: p = 32'h0001_0000 + $urandom_range(4095);
        default: p = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      endcase
      pending_words.push_back('{p, 11'(b), b == top});
    end
  endtask

  task automatic drain_all();
    wait (pending_words.size() == 0);
    @(negedge clk);
    while (bin_valid || expected_lmp.size() > 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_count(input logic [4:0] val);
    @(negedge clk);
    average_count    <= val;
    average_count_we <= 1'b1;
    @(negedge clk);
    average_count_we <= 1'b0;
    avg_reg = val;
  endtask

  initial begin
    logic [4:0] counts[6];
    counts = '{5'd0, 5'd16, 5'd31, 5'd1, 5'd3, 5'd2};
    for (int i = 0; i < ROWS; i++)
      for (int j = 0; j < BINS; j++) power_history[i][j] = '0;
    ring_row    = 0;
    avg_reg     = AVG_RESET;
    error_count = 0;
    idle_pct    = 26;
    hold_sender = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: DC, edge bins, out-of-range bins, extreme powers, all-zero history.
    pending_words.push_back('{32'hFFFF_FFFF, 11'd0, 1'b0});
    pending_words.push_back('{32'h0, 11'd1, 1'b0});
    pending_words.push_back('{32'hFFFF_FFFF, 11'd1024, 1'b0});
    pending_words.push_back('{32'h0001_0000, 11'd1025, 1'b0});
    pending_words.push_back('{32'hFFFF_FFFF, 11'd2047, 1'b1});
    pending_words.push_back('{32'h0, 11'd2, 1'b0});
    pending_words.push_back('{32'h0001_0000, 11'd1, 1'b1});
    for (int s = 0; s < 4; s++) queue_spectrum(3, s % 3);
    // Drain every expected word, then hold the sender with one word pending and release it.
    drain_all();
    hold_sender = 1'b1;
    pending_words.push_back('{32'h1234_5678, 11'd1, 1'b1});
    repeat (50) @(negedge clk);
    hold_sender = 1'b0;
    drain_all();

    // Random phases under several averaging counts; the first has no idling.
    for (int ph = 0; ph < 6; ph++) begin
      write_count(counts[ph]);
      idle_pct = (ph == 0) ? 0 : 26;
      for (int s = 0; s < 10; s++) begin
        queue_spectrum($urandom_range(1, 14), $urandom_range(2));
        if ($urandom_range(9) == 0) begin
          pending_words.push_back('{$urandom(), 11'($urandom_range(1025, 2047)),
                                    1'($urandom_range(1))});
        end
        if ($urandom_range(5) == 0) begin
          pending_words.push_back('{$urandom(), pick_bin(1024), 1'($urandom_range(1))});
        end
      end
      drain_all();
    end
    // One full-width spectrum so every bin index bit toggles.
    queue_spectrum(1024, 0);
    drain_all();

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
rtl/slmp_pkg.sv
rtl/spectral_lmp_detector.sv
sim/tb_spectral_lmp_detector.sv
